// ===== design/ffl_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, sideband types and register codes of the field limiter
package ffl_pkg;

    localparam int WORD_W = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_PAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MAG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2_FLOOR   = 2'd2;

    // restoring divider: one quotient bit per stage
    localparam int DIV_STEPS  = 64;
    localparam int DIV_DATA_W = 64;
    localparam int DIV_REM_W  = 68;

    // digit-by-digit square root: one root bit per stage
    localparam int SQ_STEPS  = 32;
    localparam int SQ_IN_W   = 2 * SQ_STEPS;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;

    // sideband that rides along the parallel-correction dividers
    typedef struct packed {
        logic [2:0][WORD_W-1:0] e;
        logic [2:0]             bneg;
        logic                   dneg;
        logic                   corr_on;
        logic [63:0]            b2;
    } t_corr_side;

    // sideband that rides along the scale divider and square root
    typedef struct packed {
        logic [2:0][WORD_W:0] m;
        logic [2:0]           eneg;
        logic                 lim;
    } t_lim_side;

    localparam int SIDE_W     = $bits(t_corr_side);
    localparam int LIM_SIDE_W = $bits(t_lim_side);

    typedef logic [SIDE_W-1:0] t_side;

    // front 6, correction div, 5 middle stages, scale div, sqrt, 2 back stages
    localparam int LATENCY = 6 + DIV_STEPS + 5 + DIV_STEPS + SQ_STEPS + 2;

endpackage

// ===== design/ffl_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, sideband carried along
module ffl_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [ffl_pkg::DIV_REM_W-1:0]  i_rem,
    input  logic [ffl_pkg::DIV_DATA_W-1:0] i_bits,
    input  logic [ffl_pkg::DIV_REM_W-1:0]  i_den,
    input  ffl_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [ffl_pkg::DIV_DATA_W-1:0] o_quo,
    output ffl_pkg::t_side                 o_side
);
    import ffl_pkg::*;

    logic                  r_valid [DIV_STEPS];
    logic [DIV_REM_W-1:0]  r_rem   [DIV_STEPS];
    logic [DIV_DATA_W-1:0] r_bits  [DIV_STEPS];
    logic [DIV_REM_W-1:0]  r_den   [DIV_STEPS];
    logic [DIV_DATA_W-1:0] r_quo   [DIV_STEPS];
    t_side                 r_side  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic                  w_vld;
        logic [DIV_REM_W-1:0]  w_rem;
        logic [DIV_DATA_W-1:0] w_bits;
        logic [DIV_REM_W-1:0]  w_den;
        logic [DIV_DATA_W-1:0] w_quo;
        t_side                 w_side;
        logic [DIV_REM_W:0]    w_trial;
        logic [DIV_REM_W:0]    w_diff;
        logic                  w_ge;

        if (k == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_rem  = i_rem;
            assign w_bits = i_bits;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_tail
            assign w_vld  = r_valid[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_bits = r_bits[k-1];
            assign w_den  = r_den[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
        end

        // bring down the next numerator bit and try the subtract
        assign w_trial = {w_rem, w_bits[DIV_DATA_W-1]};
        assign w_diff  = w_trial - {1'b0, w_den};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? w_diff[DIV_REM_W-1:0] : w_trial[DIV_REM_W-1:0];
            r_bits[k] <= {w_bits[DIV_DATA_W-2:0], 1'b0};
            r_den[k]  <= w_den;
            r_quo[k]  <= {w_quo[DIV_DATA_W-2:0], w_ge};
            r_side[k] <= w_side;
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_quo   = r_quo[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule

// ===== design/ffl_isqrt.sv =====
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage, sideband carried along
module ffl_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ffl_pkg::SQ_IN_W-1:0]   i_rad,
    input  ffl_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [ffl_pkg::SQ_ROOT_W-1:0] o_root,
    output ffl_pkg::t_side                o_side
);
    import ffl_pkg::*;

    logic                 r_valid [SQ_STEPS];
    logic [SQ_REM_W-1:0]  r_rem   [SQ_STEPS];
    logic [SQ_IN_W-1:0]   r_rad   [SQ_STEPS];
    logic [SQ_ROOT_W-1:0] r_root  [SQ_STEPS];
    t_side                r_side  [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic                 w_vld;
        logic [SQ_REM_W-1:0]  w_rem;
        logic [SQ_IN_W-1:0]   w_rad;
        logic [SQ_ROOT_W-1:0] w_root;
        t_side                w_side;
        logic [SQ_REM_W+1:0]  w_trial;
        logic [SQ_REM_W+1:0]  w_test;
        logic [SQ_REM_W+1:0]  w_diff;
        logic                 w_ge;

        if (k == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_rem  = '0;
            assign w_rad  = i_rad;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_tail
            assign w_vld  = r_valid[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_root = r_root[k-1];
            assign w_side = r_side[k-1];
        end

        // next two radicand bits against 4*root + 1
        assign w_trial = {w_rem, w_rad[SQ_IN_W-1 -: 2]};
        assign w_test  = {2'b00, w_root, 2'b01};
        assign w_diff  = w_trial - w_test;
        assign w_ge    = (w_trial >= w_test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? w_diff[SQ_REM_W-1:0] : w_trial[SQ_REM_W-1:0];
            r_rad[k]  <= {w_rad[SQ_IN_W-3:0], 2'b00};
            r_root[k] <= {w_root[SQ_ROOT_W-2:0], w_ge};
            r_side[k] <= w_side;
        end
    end

    assign o_valid = r_valid[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];

endmodule

// ===== design/force_free_efield_limiter.sv =====
`timescale 1ns / 1ps
// top level of the force-free electric field limiter pipeline
//
// one grid cell (E and B, signed q16.16) enters per clock: a beat is taken on every
// edge with start high, and busy never rises. the result beat comes out as a one-cycle
// o_valid strobe with the new E and was_limited; the receiver has no way to hold it,
// so take it on that edge. the pipe holds three bit-per-stage units in series:
// the 64-stage dividers that form the parallel correction (one per component,
// side by side), the 64-stage divider for b2 / e2, and the 32-stage square root
// of that quotient; the rest is six front stages (products, sums, floor, wide
// products split in halves), stages g to k between the dividers and l, m at the
// back. configuration writes land at once through i_cfg_we / i_cfg_index /
// i_cfg_data and apply to cells in flight, so write only while the pipe is
// empty. index 3 is ignored.
module force_free_efield_limiter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ffl_pkg::WORD_W-1:0]   i_e_x,
    input  logic signed [ffl_pkg::WORD_W-1:0]   i_e_y,
    input  logic signed [ffl_pkg::WORD_W-1:0]   i_e_z,
    input  logic signed [ffl_pkg::WORD_W-1:0]   i_b_x,
    input  logic signed [ffl_pkg::WORD_W-1:0]   i_b_y,
    input  logic signed [ffl_pkg::WORD_W-1:0]   i_b_z,
    input  logic                                i_cfg_we,
    input  logic [ffl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ffl_pkg::WORD_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic signed [ffl_pkg::WORD_W-1:0]   o_e_x_out,
    output logic signed [ffl_pkg::WORD_W-1:0]   o_e_y_out,
    output logic signed [ffl_pkg::WORD_W-1:0]   o_e_z_out,
    output logic                                o_was_limited
);
    import ffl_pkg::*;

    // saturate a sign-magnitude value to the word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic neg,
                                                          input logic [WORD_W:0] mag);
        logic signed [WORD_W-1:0] res;
        if (!neg && mag > {2'b00, {(WORD_W-1){1'b1}}}) begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (neg && mag > {2'b01, {(WORD_W-1){1'b0}}}) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else if (neg) begin
            res = WORD_W'(-mag);
        end else begin
            res = WORD_W'(mag);
        end
        return res;
    endfunction

    // configuration registers
    logic              r_cfg_rpe;
    logic              r_cfg_lme;
    logic [WORD_W-1:0] r_cfg_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rpe   <= 1'b1;
            r_cfg_lme   <= 1'b1;
            r_cfg_floor <= WORD_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REMOVE_PAR: r_cfg_rpe   <= i_cfg_data[0];
                CFG_LIMIT_MAG:  r_cfg_lme   <= i_cfg_data[0];
                CFG_B2_FLOOR:   r_cfg_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipe never stalls: a beat can enter on every edge
    assign busy = 1'b0;

    // ---------------- stage a: input capture ----------------
    logic                     r_a_valid;
    logic signed [WORD_W-1:0] r_a_e [3];
    logic signed [WORD_W-1:0] r_a_b [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_e[0] <= i_e_x;
        r_a_e[1] <= i_e_y;
        r_a_e[2] <= i_e_z;
        r_a_b[0] <= i_b_x;
        r_a_b[1] <= i_b_y;
        r_a_b[2] <= i_b_z;
    end

    // ---------------- stage b: b squares and e.b products ----------------
    logic                     r_b_valid;
    logic signed [63:0]       r_b_bb [3];
    logic signed [63:0]       r_b_eb [3];
    logic signed [WORD_W-1:0] r_b_e  [3];
    logic [WORD_W-1:0]        r_b_bm [3];
    logic [2:0]               r_b_bneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_b_bb[i]   <= 64'(r_a_b[i]) * 64'(r_a_b[i]);
            r_b_eb[i]   <= 64'(r_a_e[i]) * 64'(r_a_b[i]);
            r_b_e[i]    <= r_a_e[i];
            // magnitude of the most negative word is 2^31, fits unsigned
            r_b_bm[i]   <= r_a_b[i][WORD_W-1] ? WORD_W'(-r_a_b[i]) : WORD_W'(r_a_b[i]);
            r_b_bneg[i] <= r_a_b[i][WORD_W-1];
        end
    end

    // ---------------- stage c: sums ----------------
    logic                     r_c_valid;
    logic [63:0]              r_c_b2raw;
    logic signed [65:0]       r_c_dot;
    logic signed [WORD_W-1:0] r_c_e  [3];
    logic [WORD_W-1:0]        r_c_bm [3];
    logic [2:0]               r_c_bneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // each square is below 2^63, the sum below 2^64
        r_c_b2raw <= $unsigned(r_b_bb[0]) + $unsigned(r_b_bb[1]) + $unsigned(r_b_bb[2]);
        r_c_dot   <= 66'(r_b_eb[0]) + 66'(r_b_eb[1]) + 66'(r_b_eb[2]);
        r_c_e     <= r_b_e;
        r_c_bm    <= r_b_bm;
        r_c_bneg  <= r_b_bneg;
    end

    // ---------------- stage d: floor b2, magnitude of e.b ----------------
    logic [63:0] n_d_b2;
    logic [65:0] n_d_dabs;

    assign n_d_b2   = (r_c_b2raw < {32'b0, r_cfg_floor}) ? {32'b0, r_cfg_floor} : r_c_b2raw;
    assign n_d_dabs = r_c_dot[65] ? 66'(-r_c_dot) : 66'(r_c_dot);

    logic                     r_d_valid;
    logic [63:0]              r_d_b2;
    logic [63:0]              r_d_dm;
    logic                     r_d_dneg;
    logic                     r_d_corr_on;
    logic signed [WORD_W-1:0] r_d_e  [3];
    logic [WORD_W-1:0]        r_d_bm [3];
    logic [2:0]               r_d_bneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_b2      <= n_d_b2;
        r_d_dm      <= n_d_dabs[63:0];
        r_d_dneg    <= r_c_dot[65];
        // a zero b2 skips the correction
        r_d_corr_on <= r_cfg_rpe && (n_d_b2 != 64'd0);
        r_d_e       <= r_c_e;
        r_d_bm      <= r_c_bm;
        r_d_bneg    <= r_c_bneg;
    end

    // ---------------- stage e: |e.b| * |b_i| as two 32x32 halves ----------------
    logic                     r_e_valid;
    logic [63:0]              r_e_plo [3];
    logic [63:0]              r_e_phi [3];
    t_corr_side               r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e_plo[i]    <= 64'(r_d_dm[31:0]) * 64'(r_d_bm[i]);
            r_e_phi[i]    <= 64'(r_d_dm[63:32]) * 64'(r_d_bm[i]);
            r_e_side.e[i] <= r_d_e[i];
        end
        r_e_side.bneg    <= r_d_bneg;
        r_e_side.dneg    <= r_d_dneg;
        r_e_side.corr_on <= r_d_corr_on;
        r_e_side.b2      <= r_d_b2;
    end

    // ---------------- stage f: assemble numerators ----------------
    logic        r_f_valid;
    logic [95:0] r_f_n [3];
    t_corr_side  r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_f_n[i] <= {r_e_phi[i], 32'b0} + 96'(r_e_plo[i]);
        end
        r_f_side <= r_e_side;
    end

    // ---------------- correction dividers ----------------
    // quotient is n * 2^32 / b2; the correction is its upper half and stays
    // below |E| < 2^32, so n >> 32 is already below b2
    logic                  w_cvalid [3];
    logic [DIV_DATA_W-1:0] w_cq     [3];
    t_side                 w_cside  [3];

    for (genvar i = 0; i < 3; i++) begin : g_corr
        ffl_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_f_valid),
            .i_rem   ({4'b0, r_f_n[i][95:32]}),
            .i_bits  ({r_f_n[i][31:0], 32'b0}),
            .i_den   ({4'b0, r_f_side.b2}),
            .i_side  ((i == 0) ? t_side'(r_f_side) : t_side'(0)),
            .o_valid (w_cvalid[i]),
            .o_quo   (w_cq[i]),
            .o_side  (w_cside[i])
        );
    end

    // ---------------- stage g: apply correction ----------------
    t_corr_side       w_cs;
    logic signed [33:0] n_g_e [3];

    assign w_cs = t_corr_side'(w_cside[0]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_g_e[i] = 34'($signed(w_cs.e[i]));
            if (w_cs.corr_on) begin
                if (w_cs.dneg != w_cs.bneg[i]) begin
                    n_g_e[i] = n_g_e[i] + $signed({2'b00, w_cq[i][63:32]});
                end else begin
                    n_g_e[i] = n_g_e[i] - $signed({2'b00, w_cq[i][63:32]});
                end
            end
        end
    end

    logic               r_g_valid;
    logic signed [33:0] r_g_e [3];
    logic [63:0]        r_g_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= w_cvalid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_e  <= n_g_e;
        r_g_b2 <= w_cs.b2;
    end

    // ---------------- stage h: magnitudes ----------------
    logic              r_h_valid;
    logic [WORD_W:0]   r_h_m [3];
    logic [2:0]        r_h_eneg;
    logic [63:0]       r_h_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else begin
            r_h_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_h_m[i]    <= r_g_e[i][33] ? 33'(-r_g_e[i]) : 33'(r_g_e[i]);
            r_h_eneg[i] <= r_g_e[i][33];
        end
        r_h_b2 <= r_g_b2;
    end

    // ---------------- stage i: e squares ----------------
    logic            r_i_valid;
    logic [65:0]     r_i_sq [3];
    logic [WORD_W:0] r_i_m  [3];
    logic [2:0]      r_i_eneg;
    logic [63:0]     r_i_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else begin
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_i_sq[i] <= 66'(r_h_m[i]) * 66'(r_h_m[i]);
        end
        r_i_m    <= r_h_m;
        r_i_eneg <= r_h_eneg;
        r_i_b2   <= r_h_b2;
    end

    // ---------------- stage j: e2 sum ----------------
    logic                 r_j_valid;
    logic [DIV_REM_W-1:0] r_j_e2;
    logic [WORD_W:0]      r_j_m [3];
    logic [2:0]           r_j_eneg;
    logic [63:0]          r_j_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
        end else begin
            r_j_valid <= r_i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j_e2   <= DIV_REM_W'(r_i_sq[0]) + DIV_REM_W'(r_i_sq[1]) + DIV_REM_W'(r_i_sq[2]);
        r_j_m    <= r_i_m;
        r_j_eneg <= r_i_eneg;
        r_j_b2   <= r_i_b2;
    end

    // ---------------- stage k: limit decision ----------------
    logic                 r_k_valid;
    logic [DIV_REM_W-1:0] r_k_e2;
    logic [63:0]          r_k_b2;
    t_lim_side            r_k_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid <= 1'b0;
        end else begin
            r_k_valid <= r_j_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_e2 <= r_j_e2;
        r_k_b2 <= r_j_b2;
        for (int i = 0; i < 3; i++) begin
            r_k_side.m[i] <= r_j_m[i];
        end
        r_k_side.eneg <= r_j_eneg;
        // zero e never exceeds b2, so the divider never sees a zero divisor when used
        r_k_side.lim  <= r_cfg_lme && (r_j_e2 > {4'b0, r_j_b2});
    end

    // ---------------- scale divider: b2 * 2^64 / e2 ----------------
    logic                  w_sd_valid;
    logic [DIV_DATA_W-1:0] w_sd_q;
    t_side                 w_sd_side;

    ffl_div u_scale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_k_valid),
        .i_rem   ({4'b0, r_k_b2}),
        .i_bits  ('0),
        .i_den   (r_k_e2),
        .i_side  (SIDE_W'(r_k_side)),
        .o_valid (w_sd_valid),
        .o_quo   (w_sd_q),
        .o_side  (w_sd_side)
    );

    // ---------------- square root of the quotient ----------------
    logic                 w_rt_valid;
    logic [SQ_ROOT_W-1:0] w_root;
    t_side                w_rt_side;

    ffl_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sd_valid),
        .i_rad   (w_sd_q),
        .i_side  (w_sd_side),
        .o_valid (w_rt_valid),
        .o_root  (w_root),
        .o_side  (w_rt_side)
    );

    // ---------------- stage l: scale products ----------------
    t_lim_side w_ls;

    assign w_ls = t_lim_side'(w_rt_side[LIM_SIDE_W-1:0]);

    logic        r_l_valid;
    logic [64:0] r_l_prod [3];
    t_lim_side   r_l_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
        end else begin
            r_l_valid <= w_rt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_l_prod[i] <= 65'(w_ls.m[i]) * 65'(w_root);
        end
        r_l_side <= w_ls;
    end

    // ---------------- stage m: select, sign, saturate ----------------
    logic [WORD_W:0]          w_mag [3];
    logic signed [WORD_W-1:0] n_o_e [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_l_side.lim ? r_l_prod[i][64:32] : r_l_side.m[i];
            n_o_e[i] = sat_word(r_l_side.eneg[i], w_mag[i]);
        end
    end

    logic                     r_o_valid;
    logic                     r_o_lim;
    logic signed [WORD_W-1:0] r_o_e [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_lim   <= 1'b0;
        end else begin
            r_o_valid <= r_l_valid;
            r_o_lim   <= r_l_valid && r_l_side.lim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_e <= n_o_e;
    end

    assign o_valid       = r_o_valid;
    assign o_was_limited = r_o_lim;
    assign o_e_x_out     = r_o_e[0];
    assign o_e_y_out     = r_o_e[1];
    assign o_e_z_out     = r_o_e[2];

    // ---------------- checks ----------------
    // every result beat traces back to an accepted cell, per the package LATENCY
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching input beat");

    // limited flag only rides a result beat
    a_lim_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_was_limited |-> o_valid)
        else $error("was_limited outside a result beat");

    // scale factor is below one, so limiting never grows a component
    a_scale_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_l_valid && r_l_side.lim |->
            (r_l_prod[0][64:32] <= r_l_side.m[0]) &&
            (r_l_prod[1][64:32] <= r_l_side.m[1]) &&
            (r_l_prod[2][64:32] <= r_l_side.m[2]))
        else $error("scaled component larger than its input");

endmodule
